FILE: src/wds_pkg.sv
package wds_pkg;

    localparam int NUM_DISKS_DEF = 16;
    localparam int MAX_PICKS_DEF = 4;

    localparam int WEIGHT_W = 32;
    localparam int FREE_W   = 48;
    localparam int AMOUNT_W = 47;
    localparam int RAND_W   = 16;

    // Request codes.
    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_ALLOC  = 2'd1;
    localparam logic [1:0] REQ_FREE   = 2'd2;
    localparam logic [1:0] REQ_SELECT = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_PICKED     = 2'd0;
    localparam logic [1:0] ST_COUNT_ZERO = 2'd1;
    localparam logic [1:0] ST_TOO_FEW    = 2'd2;
    localparam logic [1:0] ST_UPDATED    = 2'd3;

    // One row of the disk table.
    typedef struct packed {
        logic [WEIGHT_W-1:0]      weight;
        logic signed [FREE_W-1:0] free_space;
        logic                     writable;
    } entry_t;

endpackage

FILE: src/wds_table.sv
module wds_table
    import wds_pkg::*;
#(
    parameter int NUM_DISKS = NUM_DISKS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_DISKS)-1:0] wr_addr,
    input  entry_t                       wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(NUM_DISKS)-1:0] rd_addr,
    output entry_t                       rd_data
);

    entry_t                 mem [NUM_DISKS];
    logic [NUM_DISKS-1:0]   valid_reg;
    entry_t                 rd_row_reg;
    logic                   rd_vld_reg;

    // Table storage, one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    // Rows never written read as the reset value, zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_row_reg : '0;

endmodule

FILE: src/weighted_disk_selector.sv
// Channel  | Handshake            | Payload
// request  | req_valid/req_ready  | req_type, disk_index, weight_value, writable_flag,
//          |                      | amount, pick_count, exclude_mask, rand_0..rand_3
// result   | res_valid/res_ready  | picked_disk, status, last_result
//
// One item is handled at a time; the table sits in one memory with a registered read.
// A set writes the row when it is taken; allocate and free read the row, then adjust and write it back.
// Select scans the table once to find candidates and the total weight and then checks
// the count and the total; each pick then takes a multiply step and a scan that stops
// at the chosen disk; the results follow, one a cycle while the receiver takes them.
// The result register lets a new item be taken while a result still waits; reset
// leaves every disk at zero weight, zero space and not writable.
module weighted_disk_selector
    import wds_pkg::*;
#(
    parameter int NUM_DISKS = NUM_DISKS_DEF,
    parameter int MAX_PICKS = MAX_PICKS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_type,
    input  logic [3:0]          disk_index,
    input  logic [WEIGHT_W-1:0] weight_value,
    input  logic                writable_flag,
    input  logic [AMOUNT_W-1:0] amount,
    input  logic [2:0]          pick_count,
    input  logic [15:0]         exclude_mask,
    input  logic [RAND_W-1:0]   rand_0,
    input  logic [RAND_W-1:0]   rand_1,
    input  logic [RAND_W-1:0]   rand_2,
    input  logic [RAND_W-1:0]   rand_3,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [3:0]          picked_disk,
    output logic [1:0]          status,
    output logic                last_result
);

    localparam int IW = $clog2(NUM_DISKS);
    localparam int CW = IW + 1;
    localparam int TW = WEIGHT_W + IW;
    localparam int PW = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPD_RD = 4'd1;
    localparam logic [3:0] S_UPD_WR = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_ROUL   = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_RES    = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [1:0]           req_reg, req_next;
    logic [3:0]           idx_reg, idx_next;
    logic [AMOUNT_W-1:0]  amt_reg, amt_next;
    logic [2:0]           count_reg, count_next;
    logic [15:0]          excl_reg, excl_next;
    logic [RAND_W-1:0]    rnd_reg [4];
    logic [RAND_W-1:0]    rnd_next [4];
    logic [CW-1:0]        scan_reg, scan_next;
    logic                 pend_reg, pend_next;
    logic [IW-1:0]        pidx_reg, pidx_next;
    logic [NUM_DISKS-1:0] pool_reg, pool_next;
    logic [CW-1:0]        ncand_reg, ncand_next;
    logic [TW-1:0]        total_reg, total_next;
    logic [TW-1:0]        acc_reg, acc_next;
    logic [TW-1:0]        thr_reg, thr_next;
    logic [PW-1:0]        n_reg, n_next;
    logic [3:0]           picks_reg [MAX_PICKS];
    logic [3:0]           picks_next [MAX_PICKS];
    logic [1:0]           stat_reg, stat_next;
    logic                 res_valid_reg, res_valid_next;
    logic [3:0]           res_disk_reg, res_disk_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic                 res_last_reg, res_last_next;

    logic                 tb_wr_en;
    logic [IW-1:0]        tb_wr_addr;
    entry_t               tb_wr_data;
    logic                 tb_rd_en;
    logic [IW-1:0]        tb_rd_addr;
    entry_t               tb_rd_data;

    wds_table #(
        .NUM_DISKS (NUM_DISKS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tb_wr_en),
        .wr_addr (tb_wr_addr),
        .wr_data (tb_wr_data),
        .rd_en   (tb_rd_en),
        .rd_addr (tb_rd_addr),
        .rd_data (tb_rd_data)
    );

    logic                 in_acc;
    logic                 slot_free;
    logic                 in_range;
    logic [6:0]           pidx7;
    logic                 excluded;
    logic                 cand;
    logic                 issue;
    logic signed [FREE_W:0] upd_sum;
    logic signed [FREE_W-1:0] upd_free;
    logic [TW+RAND_W-1:0] product;
    logic [TW-1:0]        acc_sum;
    logic [TW-1:0]        total_left;

    assign req_ready   = (state_reg == S_IDLE);
    assign in_acc      = req_valid && req_ready;
    assign slot_free   = !res_valid_reg || res_ready;
    assign res_valid   = res_valid_reg;
    assign picked_disk = res_disk_reg;
    assign status      = res_status_reg;
    assign last_result = res_last_reg;

    // Index checks and candidate test on the row coming back from the table.
    always_comb
    begin
        in_range = (7'(idx_reg) < 7'(NUM_DISKS));
        pidx7    = 7'(pidx_reg);
        excluded = (pidx7 < 7'd16) && excl_reg[pidx7[3:0]];
        cand     = tb_rd_data.writable && !tb_rd_data.free_space[FREE_W-1]
                   && (tb_rd_data.free_space != '0) && !excluded;
        issue    = ((state_reg == S_SCAN) || (state_reg == S_ROUL))
                   && (scan_reg < CW'(NUM_DISKS));
        if (req_reg == REQ_ALLOC)
        begin
            upd_sum = {tb_rd_data.free_space[FREE_W-1], tb_rd_data.free_space}
                      - (FREE_W+1)'(amt_reg);
        end
        else
        begin
            upd_sum = {tb_rd_data.free_space[FREE_W-1], tb_rd_data.free_space}
                      + (FREE_W+1)'(amt_reg);
        end
        // Saturate to the signed range of the free-space count.
        if (upd_sum[FREE_W] != upd_sum[FREE_W-1])
        begin
            upd_free = upd_sum[FREE_W] ? {1'b1, {(FREE_W-1){1'b0}}}
                                       : {1'b0, {(FREE_W-1){1'b1}}};
        end
        else
        begin
            upd_free = upd_sum[FREE_W-1:0];
        end
        product    = total_reg * rnd_reg[2'(n_reg)];
        acc_sum    = acc_reg + TW'(tb_rd_data.weight);
        total_left = total_reg - TW'(tb_rd_data.weight);
    end

    // Sequencer: table access, scans and result ordering.
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        amt_next        = amt_reg;
        count_next      = count_reg;
        excl_next       = excl_reg;
        rnd_next        = rnd_reg;
        scan_next       = scan_reg;
        pend_next       = issue;
        pidx_next       = scan_reg[IW-1:0];
        pool_next       = pool_reg;
        ncand_next      = ncand_reg;
        total_next      = total_reg;
        acc_next        = acc_reg;
        thr_next        = thr_reg;
        n_next          = n_reg;
        picks_next      = picks_reg;
        stat_next       = stat_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_disk_next   = res_disk_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;

        tb_wr_en   = 1'b0;
        tb_wr_addr = IW'(idx_reg);
        tb_wr_data = '0;
        tb_rd_en   = issue;
        tb_rd_addr = scan_reg[IW-1:0];

        if (issue)
        begin
            scan_next = scan_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    req_next    = req_type;
                    idx_next    = disk_index;
                    amt_next    = amount;
                    count_next  = pick_count;
                    excl_next   = exclude_mask;
                    rnd_next[0] = rand_0;
                    rnd_next[1] = rand_1;
                    rnd_next[2] = rand_2;
                    rnd_next[3] = rand_3;
                    scan_next   = '0;
                    ncand_next  = '0;
                    total_next  = '0;
                    pool_next   = '0;
                    n_next      = '0;
                    if (req_type != REQ_SELECT)
                    begin
                        stat_next = ST_UPDATED;
                        if (7'(disk_index) >= 7'(NUM_DISKS))
                        begin
                            state_next = S_RES;
                        end
                        else if (req_type == REQ_SET)
                        begin
                            // A set loads the whole row straight away.
                            tb_wr_en   = 1'b1;
                            tb_wr_addr = IW'(disk_index);
                            tb_wr_data = '{weight: weight_value,
                                           free_space: FREE_W'(amount),
                                           writable: writable_flag};
                            state_next = S_RES;
                        end
                        else
                        begin
                            state_next = S_UPD_RD;
                        end
                    end
                    else if (pick_count == 3'd0)
                    begin
                        stat_next  = ST_COUNT_ZERO;
                        state_next = S_RES;
                    end
                    else if (7'(pick_count) > 7'(MAX_PICKS))
                    begin
                        stat_next  = ST_TOO_FEW;
                        state_next = S_RES;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_UPD_RD:
            begin
                tb_rd_en   = 1'b1;
                tb_rd_addr = IW'(idx_reg);
                state_next = S_UPD_WR;
            end

            S_UPD_WR:
            begin
                // Write back the adjusted free-space count.
                tb_wr_en   = in_range;
                tb_wr_data = '{weight: tb_rd_data.weight, free_space: upd_free,
                               writable: tb_rd_data.writable};
                state_next = S_RES;
            end

            S_SCAN:
            begin
                if (pend_reg)
                begin
                    pool_next[pidx_reg] = cand;
                    if (cand)
                    begin
                        ncand_next = ncand_reg + 1'b1;
                        total_next = total_reg + TW'(tb_rd_data.weight);
                    end
                    if (pidx_reg == IW'(NUM_DISKS - 1))
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                if ((7'(ncand_reg) < 7'(count_reg)) || (total_reg == '0))
                begin
                    stat_next  = ST_TOO_FEW;
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                thr_next   = product[TW+RAND_W-1:RAND_W];
                acc_next   = '0;
                scan_next  = '0;
                state_next = S_ROUL;
            end

            S_ROUL:
            begin
                // Running sum over the pool; stop at the first disk reaching r.
                if (pend_reg && pool_reg[pidx_reg])
                begin
                    acc_next = acc_sum;
                    if (acc_sum >= thr_reg)
                    begin
                        picks_next[n_reg]   = 4'(pidx_reg);
                        pool_next[pidx_reg] = 1'b0;
                        total_next          = total_left;
                        if (3'(n_reg) + 3'd1 == count_reg)
                        begin
                            n_next     = '0;
                            state_next = S_EMIT;
                        end
                        else if (total_left == '0)
                        begin
                            stat_next  = ST_TOO_FEW;
                            state_next = S_RES;
                        end
                        else
                        begin
                            n_next     = n_reg + 1'b1;
                            state_next = S_MUL;
                        end
                    end
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    res_disk_next   = picks_reg[n_reg];
                    res_status_next = ST_PICKED;
                    res_last_next   = (3'(n_reg) + 3'd1 == count_reg);
                    if (3'(n_reg) + 3'd1 == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1;
                    end
                end
            end

            S_RES:
            begin
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    res_disk_next   = 4'd0;
                    res_status_next = stat_reg;
                    res_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        amt_reg        <= amt_next;
        count_reg      <= count_next;
        excl_reg       <= excl_next;
        rnd_reg        <= rnd_next;
        scan_reg       <= scan_next;
        pidx_reg       <= pidx_next;
        pool_reg       <= pool_next;
        ncand_reg      <= ncand_next;
        total_reg      <= total_next;
        acc_reg        <= acc_next;
        thr_reg        <= thr_next;
        n_reg          <= n_next;
        picks_reg      <= picks_next;
        stat_reg       <= stat_next;
        res_disk_reg   <= res_disk_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

endmodule

FILE: bench/tb_weighted_disk_selector.sv
`timescale 1ns / 1ps

module tb_weighted_disk_selector;
    import wds_pkg::*;

    localparam int NDISK = 16;
    localparam int NPICK = 4;
    localparam int STALL_LIMIT = 20000;
    localparam logic signed [FREE_W-1:0] SPACE_MAX = {1'b0, {(FREE_W-1){1'b1}}};
    localparam logic signed [FREE_W-1:0] SPACE_MIN = {1'b1, {(FREE_W-1){1'b0}}};

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [1:0]          req_type = REQ_SET;
    logic [3:0]          disk_index = '0;
    logic [WEIGHT_W-1:0] weight_value = '0;
    logic                writable_flag = 1'b0;
    logic [AMOUNT_W-1:0] amount = '0;
    logic [2:0]          pick_count = '0;
    logic [15:0]         exclude_mask = '0;
    logic [RAND_W-1:0]   rand_0 = '0;
    logic [RAND_W-1:0]   rand_1 = '0;
    logic [RAND_W-1:0]   rand_2 = '0;
    logic [RAND_W-1:0]   rand_3 = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    logic [3:0]          picked_disk;
    logic [1:0]          status;
    logic                last_result;

    typedef struct packed {
        logic [1:0]          kind;
        logic [3:0]          idx;
        logic [WEIGHT_W-1:0] weight;
        logic                wr;
        logic [AMOUNT_W-1:0] amt;
        logic [2:0]          count;
        logic [15:0]         excl;
        logic [RAND_W-1:0]   r0;
        logic [RAND_W-1:0]   r1;
        logic [RAND_W-1:0]   r2;
        logic [RAND_W-1:0]   r3;
    } request_t;

    typedef struct packed {
        logic [3:0] disk;
        logic [1:0] st;
        logic       last;
    } answer_t;

    // Predicted disk table.
    logic [WEIGHT_W-1:0]      tbl_weight [NDISK];
    logic signed [FREE_W-1:0] tbl_space [NDISK];
    logic                     tbl_wr [NDISK];

    answer_t pending_answers[$];
    int      errors = 0;
    int      answers_seen = 0;
    int      picks_seen = 0;
    int      items_sent = 0;
    int      idle_count = 0;
    bit      hold_results = 1'b0;
    bit      rx_no_gaps = 1'b0;
    bit      tx_no_gaps = 1'b0;

    weighted_disk_selector dut (.*);

    always #1 clk = ~clk;

    function automatic logic signed [FREE_W-1:0] clamp_space(logic signed [FREE_W+1:0] v);
        if (v > SPACE_MAX)
            return SPACE_MAX;
        if (v < SPACE_MIN)
            return SPACE_MIN;
        return v[FREE_W-1:0];
    endfunction

    // Add one expected answer at the tail of the queue.
    task automatic queue_answer(answer_t a);
        pending_answers = {pending_answers, a};
    endtask

    // Apply one request to the predicted table and queue the answers it causes.
    task automatic predict_answers(request_t q);
        logic [NDISK-1:0] pool;
        logic [63:0]      total;
        logic [63:0]      thresh;
        logic [63:0]      acc;
        logic [RAND_W-1:0] frac;
        logic [3:0]       picks [NPICK];
        int               ncand;
        int               pick;
        int               lastc;
        answer_t          a;
        pool = '0;
        ncand = 0;
        if (q.kind != REQ_SELECT) begin
            if (q.kind == REQ_SET) begin
                tbl_weight[q.idx] = q.weight;
                tbl_wr[q.idx] = q.wr;
                tbl_space[q.idx] = $signed({1'b0, q.amt});
            end
            else if (q.kind == REQ_ALLOC) begin
                tbl_space[q.idx] = clamp_space($signed({{2{tbl_space[q.idx][FREE_W-1]}},
                    tbl_space[q.idx]}) - $signed({3'b0, q.amt}));
            end
            else begin
                tbl_space[q.idx] = clamp_space($signed({{2{tbl_space[q.idx][FREE_W-1]}},
                    tbl_space[q.idx]}) + $signed({3'b0, q.amt}));
            end
            a = '{disk: 4'd0, st: ST_UPDATED, last: 1'b1};
            queue_answer(a);
            return;
        end
        if (q.count == 0) begin
            a = '{disk: 4'd0, st: ST_COUNT_ZERO, last: 1'b1};
            queue_answer(a);
            return;
        end
        a = '{disk: 4'd0, st: ST_TOO_FEW, last: 1'b1};
        if (q.count > NPICK) begin
            queue_answer(a);
            return;
        end
        for (int i = 0; i < NDISK; i++) begin
            if (tbl_wr[i] && tbl_space[i] > 0 && !q.excl[i]) begin
                pool[i] = 1'b1;
                ncand++;
            end
        end
        if (ncand < q.count) begin
            queue_answer(a);
            return;
        end
        for (int n = 0; n < q.count; n++) begin
            total = '0;
            acc = '0;
            pick = -1;
            lastc = -1;
            for (int i = 0; i < NDISK; i++)
                if (pool[i])
                    total += tbl_weight[i];
            if (total == 0) begin
                queue_answer(a);
                return;
            end
            frac = (n == 0) ? q.r0 : (n == 1) ? q.r1 : (n == 2) ? q.r2 : q.r3;
            thresh = (total * frac) >> 16;
            for (int i = 0; i < NDISK; i++) begin
                if (pool[i] && pick < 0) begin
                    lastc = i;
                    acc += tbl_weight[i];
                    if (acc >= thresh)
                        pick = i;
                end
            end
            if (pick < 0)
                pick = lastc;
            picks[n] = pick[3:0];
            pool[pick] = 1'b0;
        end
        for (int n = 0; n < q.count; n++) begin
            a = '{disk: picks[n], st: ST_PICKED, last: (n + 1 == q.count)};
            queue_answer(a);
        end
    endtask

    // Send one item after a random gap, predicting its answers on acceptance.
    // Valid drops only when a gap follows, or when a burst ends.
    task automatic send_item(request_t q);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        {req_type, disk_index, weight_value, writable_flag, amount, pick_count,
            exclude_mask, rand_0, rand_1, rand_2, rand_3} <= q;
        do
            @(posedge clk);
        while (!req_ready);
        predict_answers(q);
        items_sent++;
    endtask

    // Withdraw valid after the last item of a burst has been taken.
    task automatic stop_sending();
        req_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic request_t blank_item(logic [1:0] kind);
        request_t q;
        q = '0;
        q.kind = kind;
        return q;
    endfunction

    function automatic request_t set_item(int idx, logic [31:0] w, bit wr, logic [46:0] amt);
        request_t q;
        q = blank_item(REQ_SET);
        q.idx = 4'(idx);
        q.weight = w;
        q.wr = wr;
        q.amt = amt;
        return q;
    endfunction

    function automatic request_t select_item(int count, logic [15:0] excl);
        request_t q;
        q = blank_item(REQ_SELECT);
        q.count = 3'(count);
        q.excl = excl;
        q.r0 = 16'($urandom);
        q.r1 = 16'($urandom);
        q.r2 = 16'($urandom);
        q.r3 = 16'($urandom);
        return q;
    endfunction

    // Result side: check each answer as it is taken.
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_valid && res_ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected result disk %0d status %0d last %0d",
                        $time, picked_disk, status, last_result);
                    errors++;
                end
                else begin
                    answer_t e;
                    e = pending_answers.pop_front();
                    answers_seen++;
                    if (status == ST_PICKED)
                        picks_seen++;
                    if (picked_disk !== e.disk) begin
                        $display("%0t: picked_disk expected %0d actual %0d",
                            $time, e.disk, picked_disk);
                        errors++;
                    end
                    if (status !== e.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                        errors++;
                    end
                    if (last_result !== e.last) begin
                        $display("%0t: last_result expected %0d actual %0d",
                            $time, e.last, last_result);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver: random stall per item, or a long hold when asked.
    initial begin
        int wait_cycles;
        @(posedge rst_n);
        forever begin
            if (hold_results) begin
                res_ready <= 1'b0;
                @(posedge clk);
            end
            else begin
                wait_cycles = rx_no_gaps ? 0 : $urandom_range(0, 13);
                if (wait_cycles > 0) begin
                    res_ready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
                res_ready <= 1'b1;
                do
                    @(posedge clk);
                while (!res_valid);
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_updates();
        // Extremes of weight and space and an empty table select.
        send_item(select_item(1, 16'h0000));
        send_item(set_item(0, 32'hFFFF_FFFF, 1'b1, {AMOUNT_W{1'b1}}));
        send_item(set_item(15, 32'h0000_0001, 1'b1, 47'd1));
        send_item(set_item(7, 32'd0, 1'b1, 47'd100));
        begin
            request_t q;
            q = blank_item(REQ_FREE);
            q.idx = 0;
            q.amt = {AMOUNT_W{1'b1}};
            send_item(q);
            q.kind = REQ_ALLOC;
            q.idx = 15;
            send_item(q);
            send_item(q);
            send_item(q);
            q.kind = REQ_FREE;
            send_item(q);
            send_item(q);
            send_item(q);
            q.kind = REQ_ALLOC;
            q.idx = 15;
            q.amt = {AMOUNT_W{1'b1}} - 47'd5;
            send_item(q);
        end
        stop_sending();
        wait_drained();
    endtask

    task automatic test_select_cases();
        request_t q;
        for (int i = 0; i < 4; i++)
            send_item(set_item(i + 1, 32'd10 * (i + 1), 1'b1, 47'd1000));
        send_item(select_item(0, 16'h0000));
        send_item(select_item(5, 16'h0000));
        send_item(select_item(7, 16'h0000));
        send_item(select_item(4, 16'h0000));
        send_item(select_item(4, 16'h0002));
        // Only zero-weight disk left: whole item fails.
        send_item(select_item(1, 16'h801F));
        q = select_item(4, 16'h0000);
        q.r0 = 16'h0000;
        q.r1 = 16'hFFFF;
        q.r2 = 16'h0000;
        q.r3 = 16'hFFFF;
        send_item(q);
        q.r0 = 16'hFFFF;
        q.r1 = 16'hFFFF;
        q.r2 = 16'hFFFF;
        q.r3 = 16'hFFFF;
        send_item(q);
        stop_sending();
        wait_drained();
    endtask

    function automatic request_t random_item();
        request_t q;
        int sel;
        sel = $urandom_range(0, 99);
        q = '0;
        q.idx = 4'($urandom_range(0, NDISK - 1));
        q.weight = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 1000);
        q.wr = ($urandom_range(0, 4) != 0);
        q.amt = AMOUNT_W'({$urandom, $urandom});
        if ($urandom_range(0, 2) == 0)
            q.amt = AMOUNT_W'($urandom_range(0, 4000));
        if (sel < 20) begin
            q.kind = REQ_SET;
        end
        else if (sel < 40) begin
            q.kind = ($urandom_range(0, 1) == 0) ? REQ_ALLOC : REQ_FREE;
        end
        else begin
            q = select_item(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                : $urandom_range(1, 4), 16'h0000);
            q.excl = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'h0000;
            q.idx = 4'($urandom);
            q.weight = $urandom;
            q.wr = 1'($urandom);
            q.amt = AMOUNT_W'({$urandom, $urandom});
        end
        return q;
    endfunction

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++) begin
            rx_no_gaps = (i / 40) % 4 == 3;
            tx_no_gaps = (i / 40) % 4 == 2;
            send_item(random_item());
        end
        stop_sending();
        rx_no_gaps = 1'b0;
        tx_no_gaps = 1'b0;
        wait_drained();
    endtask

    task automatic test_backpressure();
        int hold;
        // Long receiver hold in its own counted loop while items keep coming.
        fork
            begin
                hold_results = 1'b1;
                hold = 0;
                while (hold < 300) begin
                    @(posedge clk);
                    hold++;
                end
                hold_results = 1'b0;
            end
            begin
                tx_no_gaps = 1'b1;
                for (int i = 0; i < 20; i++)
                    send_item(random_item());
                stop_sending();
                tx_no_gaps = 1'b0;
            end
        join
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < NDISK; i++) begin
            tbl_weight[i] = '0;
            tbl_space[i] = '0;
            tbl_wr[i] = 1'b0;
        end
        @(posedge clk);
        test_updates();
        test_select_cases();
        test_random_traffic(180);
        test_backpressure();
        test_random_traffic(180);
        $display("Covered %0d items, %0d results, %0d picked disks.",
            items_sent, answers_seen, picks_seen);
        if (errors == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
